FILE: design/qled_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qled_pkg
// Shared types, character codes and helper functions of the quoted literal
// escape decoder.
// ----------------------------------------------------------------------------
package qled_pkg;

  localparam logic [7:0] MAX_BYTES = 8'd255;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_X      = 8'h78;

  localparam logic [1:0] OCT_DIGITS = 2'd3;
  localparam logic [1:0] HEX_DIGITS = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BODY = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_OCT  = 3'd3,
    MODE_HEX  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNCLOSED = 2'd1,
    ERR_ESCAPE   = 2'd2,
    ERR_LONG     = 2'd3
  } err_e;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       literal_end;
    logic       is_string;
    err_e       error_code;
    logic       last;
  } res_t;

  // results caused by one accepted character, in order
  typedef struct packed {
    logic [1:0] n;
    res_t       r1;
    res_t       r0;
  } push_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t hex_digit(input logic [7:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.val = 4'(c - 8'h37);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } simple_t;

  function automatic simple_t simple_escape(input logic [7:0] c);
    simple_t s;
    s.ok  = 1'b1;
    s.val = c;
    unique case (c)
      CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_QMARK: s.val = c;
      8'h61:   s.val = 8'd7;   // a
      8'h62:   s.val = 8'd8;   // b
      8'h66:   s.val = 8'd12;  // f
      8'h6E:   s.val = 8'd10;  // n
      8'h72:   s.val = 8'd13;  // r
      8'h74:   s.val = 8'd9;   // t
      8'h76:   s.val = 8'd11;  // v
      default: s.ok  = 1'b0;
    endcase
    return s;
  endfunction

endpackage

FILE: design/qled_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qled_core
// Literal state and escape decode: turns one character into zero, one or two
// result items and updates the literal state when the character is accepted.
// ----------------------------------------------------------------------------
module qled_core import qled_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_char_i,
  output push_t      push_o
);

  mode_e      mode_q, mode_d;
  logic       quote_q, quote_d;
  logic [1:0] dcnt_q, dcnt_d;
  logic [8:0] esc_q, esc_d;
  logic [7:0] bcnt_q, bcnt_d;

  function automatic res_t mk(input logic hb, input logic [7:0] b, input logic fin,
                              input logic str, input err_e err);
    res_t r;
    r.has_byte    = hb;
    r.out_byte    = b;
    r.literal_end = fin;
    r.is_string   = str;
    r.error_code  = err;
    r.last        = 1'b0;
    return r;
  endfunction

  always_comb begin
    push_t      p;
    res_t       r;
    logic       push_a;
    logic [7:0] push_v;
    logic       do_body;
    logic [7:0] q;
    logic       is_oct;
    digit_t     hd;
    simple_t    se;
    logic [1:0] dn;

    mode_d  = mode_q;
    quote_d = quote_q;
    dcnt_d  = dcnt_q;
    esc_d   = esc_q;
    bcnt_d  = bcnt_q;
    p       = '0;
    r       = '0;
    push_a  = 1'b0;
    push_v  = 8'd0;
    do_body = 1'b0;
    q       = quote_q ? CH_DQUOTE : CH_SQUOTE;
    is_oct  = (in_char_i >= CH_ZERO) && (in_char_i <= CH_SEVEN);
    hd      = hex_digit(in_char_i);
    se      = simple_escape(in_char_i);
    dn      = dcnt_q + 2'd1;

    unique case (mode_q)
      MODE_BODY: begin
        do_body = 1'b1;
      end
      MODE_ESC: begin
        if (se.ok) begin
          mode_d = MODE_BODY;
          push_a = 1'b1;
          push_v = se.val;
        end else if (in_char_i == CH_X) begin
          mode_d = MODE_HEX;
          esc_d  = 9'd0;
          dcnt_d = 2'd0;
        end else if (is_oct) begin
          mode_d = MODE_OCT;
          esc_d  = {6'd0, in_char_i[2:0]};
          dcnt_d = 2'd1;
        end else begin
          r      = mk(1'b0, 8'd0, 1'b0, quote_q, ERR_ESCAPE);
          p.r0   = r;
          p.n    = 2'd1;
          mode_d = MODE_IDLE;
        end
      end
      MODE_OCT: begin
        if (is_oct && dcnt_q < OCT_DIGITS) begin
          esc_d  = {esc_q[5:0], in_char_i[2:0]};
          dcnt_d = dn;
          if (dn >= OCT_DIGITS) begin
            mode_d = MODE_BODY;
            push_a = 1'b1;
            push_v = esc_d[7:0];
          end
        end else begin
          mode_d  = MODE_BODY;
          push_a  = 1'b1;
          push_v  = esc_q[7:0];
          do_body = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hd.ok && dcnt_q < HEX_DIGITS) begin
          esc_d  = {esc_q[4:0], hd.val};
          dcnt_d = dn;
          if (dn >= HEX_DIGITS) begin
            mode_d = MODE_BODY;
            push_a = 1'b1;
            push_v = esc_d[7:0];
          end
        end else begin
          // the terminating character is handled as a body character
          mode_d  = MODE_BODY;
          push_a  = 1'b1;
          push_v  = esc_q[7:0];
          do_body = 1'b1;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        if (in_char_i == CH_SQUOTE || in_char_i == CH_DQUOTE) begin
          quote_d = (in_char_i == CH_DQUOTE);
          bcnt_d  = 8'd0;
          dcnt_d  = 2'd0;
          esc_d   = 9'd0;
          mode_d  = MODE_BODY;
        end
      end
    endcase

    if (push_a) begin
      if (bcnt_d >= MAX_BYTES) begin
        p.r0    = mk(1'b0, 8'd0, 1'b0, quote_q, ERR_LONG);
        mode_d  = MODE_IDLE;
        do_body = 1'b0;
      end else begin
        p.r0   = mk(1'b1, push_v, 1'b0, quote_q, ERR_NONE);
        bcnt_d = bcnt_d + 8'd1;
      end
      p.n = 2'd1;
    end

    if (do_body) begin
      r = '0;
      if (in_char_i == q) begin
        r      = mk(1'b0, 8'd0, 1'b1, quote_q, ERR_NONE);
        mode_d = MODE_IDLE;
      end else if (in_char_i == CH_NL) begin
        r      = mk(1'b0, 8'd0, 1'b0, quote_q, ERR_UNCLOSED);
        mode_d = MODE_IDLE;
      end else if (in_char_i == CH_BSLASH) begin
        mode_d = MODE_ESC;
      end else if (bcnt_d >= MAX_BYTES) begin
        r      = mk(1'b0, 8'd0, 1'b0, quote_q, ERR_LONG);
        mode_d = MODE_IDLE;
      end else begin
        r      = mk(1'b1, in_char_i, 1'b0, quote_q, ERR_NONE);
        bcnt_d = bcnt_d + 8'd1;
      end
      if (in_char_i != CH_BSLASH) begin
        if (p.n == 2'd0) begin
          p.r0 = r;
        end else begin
          p.r1 = r;
        end
        p.n = p.n + 2'd1;
      end
    end

    if (p.n == 2'd1) begin
      p.r0.last = 1'b1;
    end else if (p.n == 2'd2) begin
      p.r1.last = 1'b1;
    end
    push_o = p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      quote_q <= 1'b0;
      dcnt_q  <= 2'd0;
      esc_q   <= 9'd0;
      bcnt_q  <= 8'd0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      dcnt_q  <= dcnt_d;
      esc_q   <= esc_d;
      bcnt_q  <= bcnt_d;
    end
  end

  a_opens_literal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && mode_q == MODE_IDLE &&
    (in_char_i == CH_SQUOTE || in_char_i == CH_DQUOTE) |=> mode_q == MODE_BODY)
    else $error("quote in idle did not open a literal");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.n != 2'd3)
    else $error("more than two results for one character");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && push_o.n != 2'd0 && push_o.r0.has_byte |=> bcnt_q != 8'd0)
    else $error("byte count not advanced after a decoded byte");

endmodule

FILE: design/qled_res_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qled_res_queue
// Small result queue: takes up to two result items per cycle and hands them
// out one per cycle on the output handshake.
// ----------------------------------------------------------------------------
module qled_res_queue import qled_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_en_i,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  data_o
);

  res_t              ent_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;
  logic [1:0]        n_in;
  logic [QPTR_W-1:0] wr_nxt;

  assign n_in    = push_en_i ? push_i.n : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign data_o  = ent_q[rd_q];
  assign wr_nxt  = wr_q + QPTR_W'(1);

  always_comb begin
    wr_d  = wr_q + QPTR_W'(n_in);
    rd_d  = pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + QCNT_W'(n_in) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (n_in != 2'd0) begin
      ent_q[wr_q] <= push_i.r0;
    end
    if (n_in == 2'd2) begin
      ent_q[wr_nxt] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != QCNT_W'(QUEUE_DEPTH) |-> QPTR_W'(wr_q - rd_q) == QPTR_W'(cnt_q))
    else $error("queue pointers and count disagree");

endmodule

FILE: design/quoted_literal_escape_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_literal_escape_decoder_top
// Decodes quoted C literals and their escapes from a character stream.
// ----------------------------------------------------------------------------
// the results of an accepted character are registered in the result queue
// throughput: one character per cycle while in_ready_o is high; a character may
//   give two results, which leave one per cycle from a four-entry result queue
// in_ready_o is high while the queue has room for two results
// reset (rst_ni low, asynchronous) empties the queue and returns to idle
module quoted_literal_escape_decoder_top import qled_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       has_byte_o,
  output logic [7:0] out_byte_o,
  output logic       literal_end_o,
  output logic       is_string_o,
  output logic [1:0] error_code_o,
  output logic       last_o
);

  logic  accept;
  push_t push;
  res_t  res;

  assign accept = in_valid_i && in_ready_o;

  qled_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_char_i(in_char_i),
    .push_o   (push)
  );

  qled_res_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_en_i(accept),
    .push_i   (push),
    .room_o   (in_ready_o),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .data_o   (res)
  );

  assign has_byte_o    = res.has_byte;
  assign out_byte_o    = res.out_byte;
  assign literal_end_o = res.literal_end;
  assign is_string_o   = res.is_string;
  assign error_code_o  = res.error_code;
  assign last_o        = res.last;

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_byte_o |-> error_code_o == ERR_NONE && !literal_end_o)
    else $error("decoded byte item also flags end or error");

endmodule

FILE: test/tb_quoted_literal_escape_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quoted_literal_escape_decoder_top
// Self-checking bench for the quoted literal escape decoder. Characters are
// streamed in bursts, results are drained under a changing stall pattern,
// and every result is checked in order against a cycle-free decoder model.
// ----------------------------------------------------------------------------
module tb_quoted_literal_escape_decoder_top;
  import qled_pkg::*;

  localparam int unsigned RANDOM_CHARS   = 800;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 16;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC,
    STALL_LONG
  } stall_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_char_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       has_byte_o;
  logic [7:0] out_byte_o;
  logic       literal_end_o;
  logic       is_string_o;
  logic [1:0] error_code_o;
  logic       last_o;

  quoted_literal_escape_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_char_i     (in_char_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .has_byte_o    (has_byte_o),
    .out_byte_o    (out_byte_o),
    .literal_end_o (literal_end_o),
    .is_string_o   (is_string_o),
    .error_code_o  (error_code_o),
    .last_o        (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // decoder model state
  mode_e      dec_mode;
  logic       dec_dquote;
  logic [1:0] dec_digits;
  logic [8:0] dec_value;
  logic [7:0] dec_count;
  res_t       char_results[$];
  res_t       expected_q[$];

  string simple_list = "abfnrtv\\'\"?";
  string hex_list    = "0123456789abcdefABCDEF";

  int unsigned sent_chars;
  int unsigned inside_chars;
  int unsigned burst_left;
  int unsigned fail_count;
  int unsigned result_count;
  int unsigned decoded_bytes;
  int unsigned closed_literals;
  int unsigned unclosed_errors;
  int unsigned escape_errors;
  int unsigned long_errors;
  int unsigned idle_cycles;
  int unsigned stall_tick;
  int unsigned style_left;
  stall_e      stall_style;
  res_t        seen;
  res_t        want;

  function automatic void clear_decoder();
    dec_mode   = MODE_IDLE;
    dec_dquote = 1'b0;
    dec_digits = 2'd0;
    dec_value  = 9'd0;
    dec_count  = 8'd0;
    expected_q.delete();
  endfunction

  function automatic void add_result(input logic hb, input logic [7:0] b, input logic fin,
                                     input err_e err);
    res_t r;
    r.has_byte    = hb;
    r.out_byte    = b;
    r.literal_end = fin;
    r.is_string   = dec_dquote;
    r.error_code  = err;
    r.last        = 1'b0;
    char_results.push_back(r);
  endfunction

  // a decoded byte, or the length error once the literal is full
  function automatic bit emit_byte(input logic [7:0] b);
    if (dec_count >= MAX_BYTES) begin
      add_result(1'b0, 8'h00, 1'b0, ERR_LONG);
      dec_mode = MODE_IDLE;
      return 1'b0;
    end
    add_result(1'b1, b, 1'b0, ERR_NONE);
    dec_count = dec_count + 8'd1;
    return 1'b1;
  endfunction

  function automatic void body_char(input logic [7:0] c);
    if (c == (dec_dquote ? CH_DQUOTE : CH_SQUOTE)) begin
      add_result(1'b0, 8'h00, 1'b1, ERR_NONE);
      dec_mode = MODE_IDLE;
    end else if (c == CH_NL) begin
      add_result(1'b0, 8'h00, 1'b0, ERR_UNCLOSED);
      dec_mode = MODE_IDLE;
    end else if (c == CH_BSLASH) begin
      dec_mode = MODE_ESC;
    end else begin
      void'(emit_byte(c));
    end
  endfunction

  function automatic int hex_value_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void escape_char(input logic [7:0] c);
    logic [7:0] v;
    bit         simple;
    simple = 1'b1;
    v      = c;
    case (c)
      CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_QMARK: v = c;
      "a": v = 8'd7;
      "b": v = 8'd8;
      "f": v = 8'd12;
      "n": v = 8'd10;
      "r": v = 8'd13;
      "t": v = 8'd9;
      "v": v = 8'd11;
      CH_X: begin
        simple     = 1'b0;
        dec_mode   = MODE_HEX;
        dec_value  = 9'd0;
        dec_digits = 2'd0;
      end
      default: begin
        simple = 1'b0;
        if (c >= CH_ZERO && c <= CH_SEVEN) begin
          dec_mode   = MODE_OCT;
          dec_value  = {1'b0, c - CH_ZERO};
          dec_digits = 2'd1;
        end else begin
          add_result(1'b0, 8'h00, 1'b0, ERR_ESCAPE);
          dec_mode = MODE_IDLE;
        end
      end
    endcase
    if (simple) begin
      dec_mode = MODE_BODY;
      void'(emit_byte(v));
    end
  endfunction

  // works out every result one accepted character causes
  function automatic void predict_char(input logic [7:0] c);
    int   d;
    res_t r;
    char_results.delete();
    case (dec_mode)
      MODE_BODY: body_char(c);
      MODE_ESC:  escape_char(c);
      MODE_OCT: begin
        if (c >= CH_ZERO && c <= CH_SEVEN && dec_digits < OCT_DIGITS) begin
          dec_value  = dec_value * 9'd8 + {1'b0, c - CH_ZERO};
          dec_digits = dec_digits + 2'd1;
          if (dec_digits >= OCT_DIGITS) begin
            dec_mode = MODE_BODY;
            void'(emit_byte(dec_value[7:0]));
          end
        end else begin
          // terminator is handled as a body character after the byte
          dec_mode = MODE_BODY;
          if (emit_byte(dec_value[7:0])) body_char(c);
        end
      end
      MODE_HEX: begin
        d = hex_value_of(c);
        if (d >= 0 && dec_digits < HEX_DIGITS) begin
          dec_value  = dec_value * 9'd16 + 9'(d);
          dec_digits = dec_digits + 2'd1;
          if (dec_digits >= HEX_DIGITS) begin
            dec_mode = MODE_BODY;
            void'(emit_byte(dec_value[7:0]));
          end
        end else begin
          dec_mode = MODE_BODY;
          if (emit_byte(dec_value[7:0])) body_char(c);
        end
      end
      default: begin
        dec_mode = MODE_IDLE;
        if (c == CH_SQUOTE || c == CH_DQUOTE) begin
          dec_dquote = (c == CH_DQUOTE);
          dec_count  = 8'd0;
          dec_digits = 2'd0;
          dec_value  = 9'd0;
          dec_mode   = MODE_BODY;
        end
      end
    endcase
    for (int i = 0; i < char_results.size(); i++) begin
      r      = char_results[i];
      r.last = (i == char_results.size() - 1);
      expected_q.push_back(r);
    end
  endfunction

  function automatic string res_text(input res_t r);
    return $sformatf("byte_valid=%0b byte=%02h end=%0b string=%0b err=%0d last=%0b",
                     r.has_byte, r.out_byte, r.literal_end, r.is_string, r.error_code, r.last);
  endfunction

  function automatic void report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endfunction

  // any byte that stays an ordinary character inside a literal of quote q
  function automatic logic [7:0] pick_plain(input logic [7:0] q);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == q || c == CH_NL || c == CH_BSLASH) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // sender: bursts of random length, random gaps between them
  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_char_i  <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_chars++;
    if (dec_mode != MODE_IDLE) inside_chars++;
    predict_char(c);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic test_idle_bytes();
    send_char(8'h00);
    send_char(8'hFF);
    send_text("\\\nab?");
  endtask

  task automatic test_simple_escapes();
    send_text("\"\\a\\b\\f\\n\\r\\t\\v\\\\\\'\\\"\\?\"");
    send_text("'\"x'''\"\"");
  endtask

  task automatic test_octal_escapes();
    // three digits, wrap past 8 bits, and early ends by backslash, digit 8, quote
    send_text("'\\101\\7\\777\\400\\18\\1'");
  endtask

  task automatic test_hex_escapes();
    send_text("\"\\x41\\xg\\x7\\xFfz\\x\"");
  endtask

  task automatic test_error_cases();
    send_text("\"ab\n");
    send_text("'\\q");
    send_text("'\\\n");
    send_text("'\\");
    send_char(8'hFF);
    send_text("\"\\12\n");
    send_text("'\\x5\n");
    send_text("'ok'");
  endtask

  task automatic test_too_long();
    // full literal closes cleanly, then the limit hit by an escape
    send_char(CH_DQUOTE);
    repeat (MAX_BYTES) send_char(pick_plain(CH_DQUOTE));
    send_char(CH_DQUOTE);
    send_char(CH_DQUOTE);
    repeat (MAX_BYTES) send_char(pick_plain(CH_DQUOTE));
    send_text("\\n");
    // the quote that ends the octal escape is dropped, so the next one opens
    send_char(CH_SQUOTE);
    repeat (MAX_BYTES) send_char(pick_plain(CH_SQUOTE));
    send_text("\\1'''");
  endtask

  task automatic send_random_literal(input bit broken);
    logic [7:0]  q;
    int unsigned len;
    int unsigned pick;
    q   = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    len = ($urandom_range(0, 59) == 0) ? $urandom_range(240, 262) : $urandom_range(0, 10);
    send_char(q);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        send_char(pick_plain(q));
      end else if (pick == 5) begin
        send_char(CH_BSLASH);
        send_char(simple_list[$urandom_range(0, simple_list.len() - 1)]);
      end else if (pick == 6) begin
        send_char(CH_BSLASH);
        repeat ($urandom_range(1, 3)) send_char(8'(CH_ZERO + $urandom_range(0, 7)));
      end else if (pick == 7) begin
        send_char(CH_BSLASH);
        send_char(CH_X);
        repeat ($urandom_range(0, 2)) send_char(hex_list[$urandom_range(0, hex_list.len() - 1)]);
      end else if (pick == 8) begin
        send_char((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
      end else begin
        send_char(8'($urandom_range(0, 255)));
      end
      if (broken && $urandom_range(0, 7) == 0) begin
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          send_char(CH_NL);
        end else if (pick == 1) begin
          send_char(CH_BSLASH);
          send_char(8'($urandom_range(0, 255)));
        end else begin
          send_char(8'($urandom_range(0, 255)));
        end
      end
    end
    if (!broken || $urandom_range(0, 1) == 0) send_char(q);
  endtask

  task automatic test_random_text();
    int unsigned start;
    int unsigned pick;
    start = inside_chars;
    while (inside_chars - start < RANDOM_CHARS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_char(8'($urandom_range(0, 255)));
      end else begin
        send_random_literal(pick < 20);
      end
    end
  endtask

  // receiver: ready pattern switches between randomly chosen stall styles
  always @(posedge clk_i) begin
    if (style_left == 0) begin
      stall_style = stall_e'($urandom_range(0, 4));
      style_left  = $urandom_range(30, 200);
    end else begin
      style_left--;
    end
    stall_tick++;
    case (stall_style)
      STALL_NONE:     out_ready_i <= 1'b1;
      STALL_LIGHT:    out_ready_i <= ($urandom_range(0, 3) != 0);
      STALL_HEAVY:    out_ready_i <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_ready_i <= (stall_tick % 3) != 0;
      default:        out_ready_i <= (stall_tick % 32) >= 24;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.has_byte    = has_byte_o;
      seen.out_byte    = out_byte_o;
      seen.literal_end = literal_end_o;
      seen.is_string   = is_string_o;
      seen.error_code  = err_e'(error_code_o);
      seen.last        = last_o;
      result_count++;
      if (seen.has_byte) decoded_bytes++;
      if (seen.literal_end) closed_literals++;
      if (seen.error_code == ERR_UNCLOSED) unclosed_errors++;
      if (seen.error_code == ERR_ESCAPE) escape_errors++;
      if (seen.error_code == ERR_LONG) long_errors++;
      if (expected_q.size() == 0) begin
        report_failure({"result with nothing pending: ", res_text(seen)});
      end else begin
        want = expected_q.pop_front();
        if (seen.has_byte !== want.has_byte || seen.out_byte !== want.out_byte ||
            seen.literal_end !== want.literal_end || seen.is_string !== want.is_string ||
            seen.error_code !== want.error_code || seen.last !== want.last) begin
          report_failure({"expected ", res_text(want), " got ", res_text(seen)});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles, %0d results outstanding",
               $realtime, idle_cycles, expected_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    clear_decoder();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_bytes();
    test_simple_escapes();
    test_octal_escapes();
    test_hex_escapes();
    test_error_cases();
    test_too_long();
    test_random_text();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d characters (%0d inside literals); checked %0d results, %0d bytes, %0d closed",
             sent_chars, inside_chars, result_count, decoded_bytes, closed_literals);
    $display("errors seen: %0d unclosed, %0d bad escape, %0d too long; %0d mismatches",
             unclosed_errors, escape_errors, long_errors, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
